>>> hw/rtl/cmptr_pkg.sv
package cmptr_pkg;

    localparam int CMPTR_W         = 256;
    localparam int CMPTR_DIV_BITS  = 8;
    localparam int CMPTR_DIV_STAGES = CMPTR_W / CMPTR_DIV_BITS;

    localparam logic [31:0] CMPTR_TIMESPAN_RST = 32'd1209600;
    localparam logic [63:0] CMPTR_LIMIT0_RST   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CMPTR_LIMIT1_RST   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CMPTR_LIMIT2_RST   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CMPTR_LIMIT3_RST   = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [2:0] {
        REG_NO_RETARGET    = 3'd0,
        REG_USE_FIRST_BITS = 3'd1,
        REG_TARGET_TIMESPAN = 3'd2,
        REG_LIMIT_WORD0    = 3'd3,
        REG_LIMIT_WORD1    = 3'd4,
        REG_LIMIT_WORD2    = 3'd5,
        REG_LIMIT_WORD3    = 3'd6
    } cmptr_reg_t;

    // Valid bit and the pass-through copy of last_bits that ride with each item.
    typedef struct packed {
        logic        vld;
        logic [31:0] byp;
    } cmptr_tag_t;

    typedef struct packed {
        logic               no_retarget;
        logic               use_first_bits;
        logic [31:0]        timespan;
        logic [CMPTR_W-1:0] limit;
    } cmptr_cfg_t;

endpackage

>>> hw/rtl/cmptr_front.sv
module cmptr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  cmptr_pkg::cmptr_cfg_t         cfg,
    input  cmptr_pkg::cmptr_tag_t         tag_i,
    input  logic [31:0]                   last_bits,
    input  logic [31:0]                   first_bits,
    input  logic [31:0]                   last_time,
    input  logic [31:0]                   first_time,
    output cmptr_pkg::cmptr_tag_t         tag_o,
    output logic [cmptr_pkg::CMPTR_W-1:0] d_o
);
    import cmptr_pkg::*;

    logic [33:0] span_next;
    logic [22:0] mant_next;
    logic [7:0]  sbyte_next;

    logic [33:0] span_reg;
    logic [22:0] mant_reg;
    logic [7:0]  sbyte1_reg;
    cmptr_tag_t  tag1_reg;

    logic [56:0] prod_reg;
    logic [7:0]  sbyte2_reg;
    cmptr_tag_t  tag2_reg;

    logic [CMPTR_W-1:0] d_reg;
    cmptr_tag_t         tag3_reg;

    // Elapsed time clamp and compact decode.
    always_comb begin
        logic signed [34:0] span;
        logic signed [34:0] lo;
        logic signed [34:0] hi;
        logic [31:0]        sel;
        logic [7:0]         size;
        logic [4:0]         rsh;
        span = $signed({3'b000, last_time}) - $signed({3'b000, first_time});
        lo   = $signed({5'b00000, cfg.timespan[31:2]});
        hi   = $signed({1'b0, cfg.timespan, 2'b00});
        if (span < lo) begin
            span = lo;
        end
        if (span > hi) begin
            span = hi;
        end
        span_next = span[33:0];

        sel  = cfg.use_first_bits ? first_bits : last_bits;
        size = sel[31:24];
        rsh  = 5'd0;
        if (size <= 8'd3) begin
            rsh        = 5'((8'd3 - size) << 3);
            mant_next  = sel[22:0] >> rsh;
            sbyte_next = 8'd0;
        end else begin
            mant_next  = sel[22:0];
            sbyte_next = size - 8'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.vld <= 1'b0;
            tag2_reg.vld <= 1'b0;
            tag3_reg.vld <= 1'b0;
        end else if (en) begin
            tag1_reg <= tag_i;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            span_reg   <= span_next;
            mant_reg   <= mant_next;
            sbyte1_reg <= sbyte_next;
            prod_reg   <= {34'd0, mant_reg} * {23'd0, span_reg};
            sbyte2_reg <= sbyte1_reg;
            // Bits pushed past the top are lost, which is the wrap mod 2^256.
            d_reg      <= CMPTR_W'(prod_reg) << {sbyte2_reg, 3'b000};
        end
    end

    assign tag_o = tag3_reg;
    assign d_o   = d_reg;

endmodule

>>> hw/rtl/cmptr_div.sv
module cmptr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [31:0]                   divisor,
    input  cmptr_pkg::cmptr_tag_t         tag_i,
    input  logic [cmptr_pkg::CMPTR_W-1:0] d_i,
    output cmptr_pkg::cmptr_tag_t         tag_o,
    output logic [cmptr_pkg::CMPTR_W-1:0] q_o
);
    import cmptr_pkg::*;

    logic [31:0]        rem_reg  [CMPTR_DIV_STAGES];
    logic [CMPTR_W-1:0] word_reg [CMPTR_DIV_STAGES];
    cmptr_tag_t         tag_reg  [CMPTR_DIV_STAGES];

    // Restoring long division; the quotient bits shift into the dividend word.
    for (genvar k = 0; k < CMPTR_DIV_STAGES; k++) begin : g_stage
        logic [31:0]        rin;
        logic [CMPTR_W-1:0] win;
        cmptr_tag_t         tin;
        logic [31:0]        rem_next;
        logic [CMPTR_W-1:0] word_next;

        if (k == 0) begin : g_first
            assign rin = 32'd0;
            assign win = d_i;
            assign tin = tag_i;
        end else begin : g_rest
            assign rin = rem_reg[k-1];
            assign win = word_reg[k-1];
            assign tin = tag_reg[k-1];
        end

        always_comb begin
            logic [32:0]        t;
            logic [31:0]        r;
            logic [CMPTR_W-1:0] w;
            r = rin;
            w = win;
            for (int i = 0; i < CMPTR_DIV_BITS; i++) begin
                t = {r, w[CMPTR_W-1]};
                w = {w[CMPTR_W-2:0], 1'b0};
                if (t >= {1'b0, divisor}) begin
                    r    = 32'(t - {1'b0, divisor});
                    w[0] = 1'b1;
                end else begin
                    r = t[31:0];
                end
            end
            rem_next  = r;
            word_next = w;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k].vld <= 1'b0;
            end else if (en) begin
                tag_reg[k] <= tin;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                word_reg[k] <= word_next;
            end
        end
    end

    assign tag_o = tag_reg[CMPTR_DIV_STAGES-1];
    assign q_o   = word_reg[CMPTR_DIV_STAGES-1];

endmodule

>>> hw/rtl/cmptr_enc.sv
module cmptr_enc (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  cmptr_pkg::cmptr_cfg_t         cfg,
    input  cmptr_pkg::cmptr_tag_t         tag_i,
    input  logic [cmptr_pkg::CMPTR_W-1:0] q_i,
    output cmptr_pkg::cmptr_tag_t         tag_o,
    output logic [31:0]                   bits_o
);
    import cmptr_pkg::*;

    localparam int NBYTES = CMPTR_W / 8;

    logic [CMPTR_W-1:0] val_next;
    logic [NBYTES-1:0]  nz_next;
    logic [5:0]         size_next;

    logic [CMPTR_W-1:0] val1_reg;
    cmptr_tag_t         tag1_reg;
    logic [CMPTR_W-1:0] val2_reg;
    logic [NBYTES-1:0]  nz2_reg;
    cmptr_tag_t         tag2_reg;
    logic [CMPTR_W-1:0] val3_reg;
    logic [5:0]         size3_reg;
    cmptr_tag_t         tag3_reg;

    // A zero divisor yields all ones, which the limit then clamps.
    always_comb begin
        val_next = (cfg.timespan == 32'd0) ? {CMPTR_W{1'b1}} : q_i;
        if (val_next > cfg.limit) begin
            val_next = cfg.limit;
        end
    end

    always_comb begin
        for (int j = 0; j < NBYTES; j++) begin
            nz_next[j] = |val1_reg[8*j +: 8];
        end
    end

    always_comb begin
        size_next = 6'd0;
        for (int j = 0; j < NBYTES; j++) begin
            if (nz2_reg[j]) begin
                size_next = 6'(j + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.vld <= 1'b0;
            tag2_reg.vld <= 1'b0;
            tag3_reg.vld <= 1'b0;
        end else if (en) begin
            tag1_reg <= tag_i;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val1_reg  <= val_next;
            val2_reg  <= val1_reg;
            nz2_reg   <= nz_next;
            val3_reg  <= val2_reg;
            size3_reg <= size_next;
        end
    end

    // Top three bytes become the mantissa; a set sign bit bumps the exponent.
    always_comb begin
        logic [8:0]  shamt;
        logic [23:0] mant;
        logic [7:0]  expo;
        if (size3_reg <= 6'd3) begin
            shamt = 9'(6'd3 - size3_reg) << 3;
            mant  = 24'(val3_reg[31:0] << shamt);
        end else begin
            shamt = 9'(size3_reg - 6'd3) << 3;
            mant  = 24'(val3_reg >> shamt);
        end
        expo = {2'b00, size3_reg};
        if (mant[23]) begin
            mant = mant >> 8;
            expo = expo + 8'd1;
        end
        bits_o = {expo, mant};
    end

    assign tag_o = tag3_reg;

endmodule

>>> hw/rtl/compact_target_retarget.sv
// Items go through the front end, divider, encoder and output register to m_*.
// Throughput: one item per cycle; the 32-stage divider (8 quotient bits per
// stage) sets the depth, and every stage takes a new item each cycle.
// A stall on the result side holds the whole pipeline in place.
// Reset (aresetn low at a clock edge) clears all valid bits and loads the
// register reset values; no clearing pass is needed.
module compact_target_retarget (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_last_bits,
    input  logic [31:0] s_first_bits,
    input  logic [31:0] s_last_time,
    input  logic [31:0] s_first_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_bits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import cmptr_pkg::*;

    logic        no_retarget_reg;
    logic        use_first_bits_reg;
    logic [31:0] timespan_reg;
    logic [63:0] limit0_reg;
    logic [63:0] limit1_reg;
    logic [63:0] limit2_reg;
    logic [63:0] limit3_reg;

    cmptr_cfg_t  cfg;
    cmptr_reg_t  reg_idx;
    logic        wr_en;
    logic        en;

    cmptr_tag_t         tag_in;
    cmptr_tag_t         tag_f;
    cmptr_tag_t         tag_d;
    cmptr_tag_t         tag_e;
    logic [CMPTR_W-1:0] d_f;
    logic [CMPTR_W-1:0] q_d;
    logic [31:0]        bits_e;

    logic        out_valid_reg;
    logic [31:0] next_bits_reg;

    assign pready  = 1'b1;
    assign reg_idx = cmptr_reg_t'(paddr[5:3]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_retarget_reg    <= 1'b0;
            use_first_bits_reg <= 1'b0;
            timespan_reg       <= CMPTR_TIMESPAN_RST;
            limit0_reg         <= CMPTR_LIMIT0_RST;
            limit1_reg         <= CMPTR_LIMIT1_RST;
            limit2_reg         <= CMPTR_LIMIT2_RST;
            limit3_reg         <= CMPTR_LIMIT3_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_NO_RETARGET:     no_retarget_reg    <= pwdata[0];
                REG_USE_FIRST_BITS:  use_first_bits_reg <= pwdata[0];
                REG_TARGET_TIMESPAN: timespan_reg       <= pwdata[31:0];
                REG_LIMIT_WORD0:     limit0_reg         <= pwdata;
                REG_LIMIT_WORD1:     limit1_reg         <= pwdata;
                REG_LIMIT_WORD2:     limit2_reg         <= pwdata;
                REG_LIMIT_WORD3:     limit3_reg         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NO_RETARGET:     prdata = {63'd0, no_retarget_reg};
            REG_USE_FIRST_BITS:  prdata = {63'd0, use_first_bits_reg};
            REG_TARGET_TIMESPAN: prdata = {32'd0, timespan_reg};
            REG_LIMIT_WORD0:     prdata = limit0_reg;
            REG_LIMIT_WORD1:     prdata = limit1_reg;
            REG_LIMIT_WORD2:     prdata = limit2_reg;
            REG_LIMIT_WORD3:     prdata = limit3_reg;
            default:             prdata = 64'd0;
        endcase
    end

    assign cfg.no_retarget    = no_retarget_reg;
    assign cfg.use_first_bits = use_first_bits_reg;
    assign cfg.timespan       = timespan_reg;
    assign cfg.limit          = {limit3_reg, limit2_reg, limit1_reg, limit0_reg};

    // The pipeline moves whenever the output register is empty or being drained.
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    assign tag_in.vld = s_valid;
    assign tag_in.byp = s_last_bits;

    cmptr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .cfg        (cfg),
        .tag_i      (tag_in),
        .last_bits  (s_last_bits),
        .first_bits (s_first_bits),
        .last_time  (s_last_time),
        .first_time (s_first_time),
        .tag_o      (tag_f),
        .d_o        (d_f)
    );

    cmptr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .divisor (timespan_reg),
        .tag_i   (tag_f),
        .d_i     (d_f),
        .tag_o   (tag_d),
        .q_o     (q_d)
    );

    cmptr_enc u_enc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .cfg     (cfg),
        .tag_i   (tag_d),
        .q_i     (q_d),
        .tag_o   (tag_e),
        .bits_o  (bits_e)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= tag_e.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            next_bits_reg <= no_retarget_reg ? tag_e.byp : bits_e;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_next_bits = next_bits_reg;

`ifndef ASSERT_OFF
    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while the output transfer is stalled");

    a_sign_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !no_retarget_reg) |-> !m_next_bits[23])
        else $error("sign bit set on a retargeted result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
